### hdl/m4xf_pkg.sv
// Package for the 4x4 matrix transform accumulator: mode codes, float constants,
// and the single-precision multiply and add functions used by the datapath.
// No dependencies.
package m4xf_pkg;

    localparam int unsigned ELEMS = 16;
    localparam int unsigned IDX_W = 4;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO = 32'h0000_0000;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    localparam logic [2:0] MODE_IDENT     = 3'd0;
    localparam logic [2:0] MODE_TRANSLATE = 3'd1;
    localparam logic [2:0] MODE_SCALE     = 3'd2;
    localparam logic [2:0] MODE_LOAD      = 3'd3;
    localparam logic [2:0] MODE_READ      = 3'd4;

    // input word of the block
    typedef struct packed {
        logic [2:0]       mode;
        logic [IDX_W-1:0] elem_index;
        logic [31:0]      value_a;
        logic [31:0]      value_b;
        logic [31:0]      value_c;
        logic             last_elem;
    } m4xf_in_t;

    // result word of the block
    typedef struct packed {
        logic [31:0] read_data;
        logic        op_done;
    } m4xf_out_t;

    // operand source for a multiply
    typedef enum logic [1:0] {
        OPSRC_MEM   = 2'd0,
        OPSRC_TRANS = 2'd1,
        OPSRC_SCALE = 2'd2
    } opsrc_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       set_ident;
        logic       op_write;
        logic       latch_xyz;
        opsrc_t     src;
        logic       mul_en;
        logic       add_en;
        logic       first_k;
        logic       store_res;
        logic       commit;
        logic [1:0] col;
        logic [1:0] row;
        logic [1:0] k;
    } m4xf_cmd_t;

    // round a non-negative extended mantissa and pack; exp is biased, may be <= 0.
    // mant has its leading one at bit 26 when normalized (27-bit incl. 3 guard bits
    // plus sticky in bit 0).
    function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [10:0] exp,
                                            input logic [26:0] mant);
        logic [26:0] m;
        logic signed [10:0] e;
        logic [5:0] sh;
        logic [26:0] lost;
        logic [24:0] r;
        logic rb, st;
        m = mant;
        e = exp;
        if (e < 11'sd1)
        begin
            // denormal: shift right with sticky
            if (e < -11'sd26)
                sh = 6'd27;
            else
                sh = 6'(11'sd1 - e);
            lost = (sh >= 6'd27) ? m : (m & ((27'd1 << sh) - 27'd1));
            m = (sh >= 6'd27) ? 27'd0 : (m >> sh);
            m[0] = m[0] | (|lost);
            e = 11'sd0;
        end
        rb = m[2];
        st = m[1] | m[0];
        r = {1'b0, m[26:3]};
        if (rb && (st || r[0]))
            r = r + 25'd1;
        if (r[24])
        begin
            r = r >> 1;
            e = e + 11'sd1;
        end
        else if (e == 11'sd0 && r[23])
            e = 11'sd1;
        if (e >= 11'sd255)
            return {sgn, 8'hFF, 23'd0};
        return {sgn, e[7:0], r[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic sa, sb, s;
        logic [7:0] ea, eb;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic signed [10:0] e;
        logic [5:0] lz;
        logic [26:0] m;
        logic found;
        sa = a[31]; sb = b[31]; s = sa ^ sb;
        ea = a[30:23]; eb = b[30:23];
        ma = {(ea != 8'd0), a[22:0]};
        mb = {(eb != 8'd0), b[22:0]};
        if ((ea == 8'hFF && a[22:0] != 23'd0) || (eb == 8'hFF && b[22:0] != 23'd0))
            return FP_QNAN;
        if (ea == 8'hFF || eb == 8'hFF)
        begin
            if ((ea == 8'd0 && a[22:0] == 23'd0) || (eb == 8'd0 && b[22:0] == 23'd0))
                return FP_QNAN;
            return {s, 8'hFF, 23'd0};
        end
        p = ma * mb;
        if (p == 48'd0)
            return {s, 31'd0};
        e = 11'($signed({3'd0, (ea == 8'd0) ? 8'd1 : ea}))
          + 11'($signed({3'd0, (eb == 8'd0) ? 8'd1 : eb})) - 11'sd126;
        // normalize so the leading one sits at bit 47
        lz = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && p[i])
            begin
                lz = 6'(47 - i);
                found = 1'b1;
            end
        end
        p = p << lz;
        e = e - 11'($signed({5'd0, lz}));
        m = {p[47:22], |p[21:0]};
        return fp_pack(s, e, m);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic [7:0] ex, ey;
        logic [26:0] mx, my, lost;
        logic [27:0] sum;
        logic [7:0] d;
        logic signed [10:0] e;
        logic [4:0] lz;
        logic found, sub;
        if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0))
            return FP_QNAN;
        if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
            return (a[31] == b[31]) ? a : FP_QNAN;
        if (a[30:23] == 8'hFF)
            return a;
        if (b[30:23] == 8'hFF)
            return b;
        if (a[30:0] >= b[30:0])
        begin
            x = a; y = b;
        end
        else
        begin
            x = b; y = a;
        end
        ex = x[30:23]; ey = y[30:23];
        mx = {(ex != 8'd0), x[22:0], 3'd0};
        my = {(ey != 8'd0), y[22:0], 3'd0};
        ex = (ex == 8'd0) ? 8'd1 : ex;
        ey = (ey == 8'd0) ? 8'd1 : ey;
        d = ex - ey;
        if (d > 8'd26)
        begin
            my = {26'd0, |my};
        end
        else
        begin
            lost = my & ((27'd1 << d) - 27'd1);
            my = my >> d;
            my[0] = my[0] | (|lost);
        end
        sub = x[31] ^ y[31];
        sum = sub ? ({1'b0, mx} - {1'b0, my}) : ({1'b0, mx} + {1'b0, my});
        if (sum == 28'd0)
            return {(x[31] & y[31]), 31'd0};
        e = 11'($signed({3'd0, ex}));
        if (sum[27])
        begin
            sum = {1'b0, sum[27:2], sum[1] | sum[0]};
            e = e + 11'sd1;
        end
        lz = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && sum[i])
            begin
                lz = 5'(26 - i);
                found = 1'b1;
            end
        end
        // stop at the denormal boundary
        if (11'($signed({6'd0, lz})) > e - 11'sd1)
            lz = 5'(e - 11'sd1);
        sum = sum << lz;
        e = e - 11'($signed({6'd0, lz}));
        if (!sum[26])
        begin
            // denormal on the e=1 grid: pre-scale so the packer's one-step shift cancels
            sum = sum << 1;
            e = 11'sd0;
        end
        return fp_pack(x[31], e, sum[26:0]);
    endfunction

endpackage

### hdl/m4xf_stream_if.sv
// Valid/ready channel carrying a generic payload type.
// Depends on m4xf_pkg only through the payload type given by the user.
interface m4xf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/m4xf_ctrl.sv
// Controller of the matrix transform accumulator: sequences the 64 products
// of a multiply and the result handshake. Depends on m4xf_pkg.
module m4xf_ctrl
    import m4xf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] in_mode,
    input  logic       in_last,
    output logic       in_ready,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       res_done,
    output m4xf_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ADD  = 5'b00100,
        S_COMM = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    opsrc_t src_reg, src_next;
    logic done_reg, done_next;
    logic accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_done  = done_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        src_next   = src_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.src    = src_reg;
        cmd.col    = cnt_reg[5:4];
        cmd.row    = cnt_reg[3:2];
        cmd.k      = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next  = (in_mode <= MODE_READ);
                    state_next = S_OUT;
                    cnt_next   = 6'd0;
                    cmd.latch_xyz = 1'b1;
                    unique case (in_mode)
                        MODE_IDENT:     cmd.set_ident = 1'b1;
                        MODE_TRANSLATE:
                        begin
                            src_next = OPSRC_TRANS;
                            state_next = S_MUL;
                        end
                        MODE_SCALE:
                        begin
                            src_next = OPSRC_SCALE;
                            state_next = S_MUL;
                        end
                        MODE_LOAD:
                        begin
                            cmd.op_write = 1'b1;
                            src_next = OPSRC_MEM;
                            if (in_last)
                                state_next = S_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_en  = 1'b1;
                cmd.first_k = (cnt_reg[1:0] == 2'd0);
                cmd.store_res = (cnt_reg[1:0] == 2'd3);
                cnt_next = cnt_reg + 6'd1;
                state_next = (cnt_reg == 6'd63) ? S_COMM : S_MUL;
            end
            S_COMM:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 6'd0;
            src_reg   <= OPSRC_MEM;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            src_reg   <= src_next;
            done_reg  <= done_next;
        end
    end

endmodule

### hdl/m4xf_datapath.sv
// Datapath: current and operand matrices, shared multiplier and adder,
// result buffer. Depends on m4xf_pkg.
module m4xf_datapath
    import m4xf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  m4xf_cmd_t        cmd,
    input  logic             accept,
    input  logic [2:0]       mode,
    input  logic [IDX_W-1:0] elem_index,
    input  logic [31:0]      value_a,
    input  logic [31:0]      value_b,
    input  logic [31:0]      value_c,
    output logic [31:0]      read_data
);

    logic [31:0] cur_reg [ELEMS];
    logic        cur_set_reg [ELEMS];   // set: element is taken from cur_reg; clear: identity value
    logic [31:0] opm_reg [ELEMS];
    logic [31:0] new_reg [ELEMS];
    logic [31:0] x_reg, y_reg, z_reg;
    logic [31:0] prod_reg, acc_reg, rd_reg;
    logic [IDX_W-1:0] op_idx, cur_idx;
    logic [31:0] op_val, cur_val, sum;

    function automatic logic [31:0] cur_at(input logic [IDX_W-1:0] i,
                                           input logic [31:0] v, input logic s);
        if (s)
            return v;
        return (i[1:0] == i[3:2]) ? FP_ONE : FP_ZERO;
    endfunction

    assign op_idx  = {cmd.col, cmd.k};
    assign cur_idx = {cmd.k, cmd.row};

    always_comb
    begin
        unique case (cmd.src)
            OPSRC_TRANS:
            begin
                if (op_idx == 4'd12)
                    op_val = x_reg;
                else if (op_idx == 4'd13)
                    op_val = y_reg;
                else if (op_idx == 4'd14)
                    op_val = z_reg;
                else
                    op_val = (cmd.col == cmd.k) ? FP_ONE : FP_ZERO;
            end
            OPSRC_SCALE:
            begin
                if (op_idx == 4'd0)
                    op_val = x_reg;
                else if (op_idx == 4'd5)
                    op_val = y_reg;
                else if (op_idx == 4'd10)
                    op_val = z_reg;
                else
                    op_val = (cmd.col == cmd.k) ? FP_ONE : FP_ZERO;
            end
            default: op_val = opm_reg[op_idx];
        endcase
    end

    assign cur_val = cur_at(cur_idx, cur_reg[cur_idx], cur_set_reg[cur_idx]);
    assign sum = cmd.first_k ? prod_reg : fp_add(acc_reg, prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ELEMS; i++)
                cur_set_reg[i] <= 1'b0;
        end
        else if (cmd.set_ident)
        begin
            for (int i = 0; i < ELEMS; i++)
                cur_set_reg[i] <= 1'b0;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < ELEMS; i++)
                cur_set_reg[i] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_xyz)
        begin
            x_reg <= value_a;
            y_reg <= value_b;
            z_reg <= value_c;
        end
        if (cmd.op_write)
            opm_reg[elem_index] <= value_a;
        if (cmd.mul_en)
            prod_reg <= fp_mul(op_val, cur_val);
        if (cmd.add_en)
            acc_reg <= sum;
        if (cmd.store_res)
            new_reg[{cmd.col, cmd.row}] <= sum;
        if (cmd.commit)
        begin
            for (int i = 0; i < ELEMS; i++)
                cur_reg[i] <= new_reg[i];
        end
        if (accept)
            rd_reg <= (mode == MODE_READ)
                    ? cur_at(elem_index, cur_reg[elem_index], cur_set_reg[elem_index])
                    : 32'd0;
    end

    assign read_data = rd_reg;

endmodule

### hdl/matrix4_transform_accumulator.sv
// Channel   Dir  Payload
// in        in   mode, elem_index, value_a, value_b, value_c, last_elem
// out       out  read_data, op_done
//
// Identity, load-without-last, read and unused modes: result word in the next cycle.
// Translate, scale and load-with-last run 64 products through one shared
// multiplier and adder (S_MUL then S_ADD per product), then commit, then result word.
// One item at a time; a stalled result holds the block. Reset restores identity.
// Top level: wires the controller and datapath. Depends on m4xf_pkg, m4xf_stream_if.
module matrix4_transform_accumulator
    import m4xf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    m4xf_stream_if.sink   in,
    m4xf_stream_if.source out
);

    m4xf_cmd_t cmd;
    logic      done;

    m4xf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_mode   (in.data.mode),
        .in_last   (in.data.last_elem),
        .in_ready  (in.ready),
        .res_valid (out.valid),
        .res_ready (out.ready),
        .res_done  (done),
        .cmd       (cmd)
    );

    m4xf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .accept     (in.valid && in.ready),
        .mode       (in.data.mode),
        .elem_index (in.data.elem_index),
        .value_a    (in.data.value_a),
        .value_b    (in.data.value_b),
        .value_c    (in.data.value_c),
        .read_data  (out.data.read_data)
    );

    assign out.data.op_done = done;

endmodule

### hdl/m4xf_checker.sv
// Port-level checker for the matrix transform accumulator, bound to the top.
// Depends on m4xf_stream_if.
module m4xf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_op_done,
    input logic [31:0] out_read_data
);

    // a result word is pending: no new input taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_read_data)
        && $stable(out_op_done)) else $error("result dropped under stall");

    a_zero_when_undone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_op_done) |-> out_read_data == 32'd0)
        else $error("data on unused mode");

endmodule

bind matrix4_transform_accumulator m4xf_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in.valid),
    .in_ready      (in.ready),
    .out_valid     (out.valid),
    .out_ready     (out.ready),
    .out_op_done   (out.data.op_done),
    .out_read_data (out.data.read_data)
);
